// ===== src/evg_pkg.sv =====
// ============================================================================
// evg_pkg: shared types and constants of the ellipsoid vertex generator
// Payload structs, pipeline sideband types, Taylor step constants and the
// saturation helper for the final coordinates.
// ============================================================================
`default_nettype none

package evg_pkg;

    // Number formats.
    localparam int FRAC_BITS    = 16;
    localparam int MAX_SEGMENTS = 1024;
    localparam int TRIG_MW      = FRAC_BITS + 1;

    // Quarter turn to radians, Q30.
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;

    // Pipelined divider geometry.
    localparam int DIV_NW  = 43;
    localparam int DIV_DW  = 13;
    localparam int DIV_QW  = 32;
    localparam int DIV_LAT = DIV_QW + 1;

    // Taylor series: six recurrence steps give seven terms per function.
    localparam int TAY_STEPS = 6;
    localparam int TRIG_LAT  = 3 + 3 * TAY_STEPS + 2;

    localparam longint unsigned TWO_32 = 64'd4294967296;

    localparam int unsigned SIN_DIV [TAY_STEPS] = '{6, 20, 42, 72, 110, 156};
    localparam int unsigned COS_DIV [TAY_STEPS] = '{2, 12, 30, 56, 90, 132};

    localparam logic [31:0] SIN_RCP [TAY_STEPS] = '{
        32'(TWO_32 / 6), 32'(TWO_32 / 20), 32'(TWO_32 / 42),
        32'(TWO_32 / 72), 32'(TWO_32 / 110), 32'(TWO_32 / 156)
    };
    localparam logic [31:0] COS_RCP [TAY_STEPS] = '{
        32'(TWO_32 / 2), 32'(TWO_32 / 12), 32'(TWO_32 / 30),
        32'(TWO_32 / 56), 32'(TWO_32 / 90), 32'(TWO_32 / 132)
    };

    typedef enum logic [2:0] {
        CFG_RADIUS_A = 3'd0,
        CFG_RADIUS_B = 3'd1,
        CFG_RADIUS_C = 3'd2,
        CFG_LON_SEG  = 3'd3,
        CFG_LAT_SEG  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [11:0] lat_index;
        logic        [10:0] lon_index;
    } t_evg_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [16:0] tex_u;
        logic        [16:0] tex_v;
        logic               pos_valid;
        logic               index_error;
    } t_evg_out;

    // State carried between Taylor steps.
    typedef struct packed {
        logic        [31:0] ts;
        logic        [31:0] tc;
        logic signed [33:0] acc_s;
        logic signed [33:0] acc_c;
        logic        [31:0] x2;
        logic        [1:0]  q;
    } t_evg_tay;

    // Sine and cosine in sign-magnitude form.
    typedef struct packed {
        logic               sin_neg;
        logic [TRIG_MW-1:0] sin_mag;
        logic               cos_neg;
        logic [TRIG_MW-1:0] cos_mag;
    } t_evg_trig;

    function automatic logic signed [31:0] sat32(input logic neg, input logic [35:0] mag);
        logic signed [31:0] res;
        if (neg) begin
            if (mag > 36'h0_8000_0000) begin
                res = 32'sh8000_0000;
            end else begin
                res = signed'(32'(~mag + 36'd1));
            end
        end else begin
            if (mag > 36'h0_7FFF_FFFF) begin
                res = 32'sh7FFF_FFFF;
            end else begin
                res = signed'(mag[31:0]);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/evg_dly.sv =====
// ============================================================================
// evg_dly: sideband delay line
// Shifts a word through N registers so it stays aligned with the datapath.
// ============================================================================
`default_nettype none

module evg_dly import evg_pkg::*; #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_d,
    output logic      [W-1:0] o_d
);

    logic [W-1:0] r_d [0:N-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_d[k] <= r_d[k-1];
            end
        end
    end

    assign o_d = r_d[N-1];

endmodule

`default_nettype wire

// ===== src/evg_div.sv =====
// ============================================================================
// evg_div: pipelined restoring divider
// One quotient bit per register stage, most significant bit first.
// ============================================================================
`default_nettype none

module evg_div import evg_pkg::*; #(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW,
    parameter int QW = DIV_QW
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [QW-1:0] o_quo
);

    localparam int CW = DW + QW;

    logic [NW-1:0] r_rem [0:QW-1];
    logic [DW-1:0] r_den [0:QW-1];
    logic [QW-1:0] r_q   [0:QW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [CW-1:0] w_sh;
        logic [CW-1:0] w_rem;
        logic          w_ge;

        assign w_sh  = CW'(r_den[k]) << (QW - 1 - k);
        assign w_rem = CW'(r_rem[k]);
        assign w_ge  = (w_rem >= w_sh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k+1] <= {r_q[k][QW-2:0], w_ge};
            end
        end

        if (k < QW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= w_ge ? NW'(w_rem - w_sh) : r_rem[k];
                    r_den[k+1] <= r_den[k];
                end
            end
        end
    end

    assign o_quo = r_q[QW];

endmodule

`default_nettype wire

// ===== src/evg_tstep.sv =====
// ============================================================================
// evg_tstep: one Taylor recurrence step for sine and cosine
// Adds the current term to each sum, or subtracts it if NEG, and forms
// the next term as ((t * x^2) >> 30) / d by reciprocal and correction.
// ============================================================================
`default_nettype none

module evg_tstep import evg_pkg::*; #(
    parameter int unsigned SIN_D = 6,
    parameter logic [31:0] SIN_R = 32'd715827882,
    parameter int unsigned COS_D = 2,
    parameter logic [31:0] COS_R = 32'h8000_0000,
    parameter bit          NEG   = 1'b0
) (
    input  wire logic     i_clk,
    input  wire logic     i_en,
    input  wire t_evg_tay i_tay,
    output t_evg_tay      o_tay
);

    // Stage A: products with x^2, running sums.
    logic        [63:0] w_ps, w_pc;
    logic signed [33:0] w_ts, w_tc;
    logic        [31:0] r_a_ps, r_a_pc, r_a_x2;
    logic signed [33:0] r_a_as, r_a_ac;
    logic        [1:0]  r_a_q;

    assign w_ps = 64'(i_tay.ts) * 64'(i_tay.x2);
    assign w_pc = 64'(i_tay.tc) * 64'(i_tay.x2);
    assign w_ts = signed'({2'b00, i_tay.ts});
    assign w_tc = signed'({2'b00, i_tay.tc});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ps <= w_ps[61:30];
            r_a_pc <= w_pc[61:30];
            r_a_as <= NEG ? (i_tay.acc_s - w_ts) : (i_tay.acc_s + w_ts);
            r_a_ac <= NEG ? (i_tay.acc_c - w_tc) : (i_tay.acc_c + w_tc);
            r_a_x2 <= i_tay.x2;
            r_a_q  <= i_tay.q;
        end
    end

    // Stage B: quotient estimate, at most one below the true quotient.
    logic        [63:0] w_qs, w_qc;
    logic        [31:0] r_b_ps, r_b_pc, r_b_qs, r_b_qc, r_b_x2;
    logic signed [33:0] r_b_as, r_b_ac;
    logic        [1:0]  r_b_q;

    assign w_qs = 64'(r_a_ps) * 64'(SIN_R);
    assign w_qc = 64'(r_a_pc) * 64'(COS_R);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_qs <= w_qs[63:32];
            r_b_qc <= w_qc[63:32];
            r_b_ps <= r_a_ps;
            r_b_pc <= r_a_pc;
            r_b_as <= r_a_as;
            r_b_ac <= r_a_ac;
            r_b_x2 <= r_a_x2;
            r_b_q  <= r_a_q;
        end
    end

    // Stage C: correct the estimate from the remainder.
    logic [39:0] w_rs, w_rc;
    t_evg_tay    r_c;

    assign w_rs = 40'(r_b_ps) - 40'(r_b_qs) * 40'(SIN_D);
    assign w_rc = 40'(r_b_pc) - 40'(r_b_qc) * 40'(COS_D);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c.ts    <= r_b_qs + 32'(w_rs >= 40'(SIN_D));
            r_c.tc    <= r_b_qc + 32'(w_rc >= 40'(COS_D));
            r_c.acc_s <= r_b_as;
            r_c.acc_c <= r_b_ac;
            r_c.x2    <= r_b_x2;
            r_c.q     <= r_b_q;
        end
    end

    assign o_tay = r_c;

endmodule

`default_nettype wire

// ===== src/evg_trig.sv =====
// ============================================================================
// evg_trig: pipelined sine and cosine of a 32-bit turn fraction
// Quadrant split, Taylor series on the first quadrant, clamp, rounding to
// FRAC_BITS and quadrant mapping to sign-magnitude outputs.
// ============================================================================
`default_nettype none

module evg_trig import evg_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_phase,
    output t_evg_trig        o_trig
);

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;

    localparam logic [31:0] RND = 32'(1) << (29 - FRAC_BITS);

    logic [31:0] r_ph;
    logic [30:0] r_x1;
    logic [1:0]  r_q1;
    logic [31:0] r_x2, r_xs;
    logic [1:0]  r_q2;
    logic [60:0] w_xp;
    logic [61:0] w_sq;

    assign w_xp = 61'(r_ph[29:0]) * 61'(HALF_PI_Q30);
    assign w_sq = 62'(r_x1) * 62'(r_x1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph <= i_phase;
            r_x1 <= w_xp[60:30];
            r_q1 <= r_ph[31:30];
            r_x2 <= w_sq[61:30];
            r_xs <= 32'(r_x1);
            r_q2 <= r_q1;
        end
    end

    t_evg_tay w_tay [0:TAY_STEPS];

    always_comb begin
        w_tay[0].ts    = r_xs;
        w_tay[0].tc    = ONE_Q30;
        w_tay[0].acc_s = '0;
        w_tay[0].acc_c = '0;
        w_tay[0].x2    = r_x2;
        w_tay[0].q     = r_q2;
    end

    for (genvar k = 0; k < TAY_STEPS; k++) begin : g_step
        evg_tstep #(
            .SIN_D (SIN_DIV[k]),
            .SIN_R (SIN_RCP[k]),
            .COS_D (COS_DIV[k]),
            .COS_R (COS_RCP[k]),
            .NEG   ((k % 2) == 1)
        ) u_step (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_tay (w_tay[k]),
            .o_tay (w_tay[k+1])
        );
    end

    function automatic logic [30:0] clamp_q30(input logic signed [33:0] v);
        logic [30:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > signed'({2'b00, ONE_Q30})) begin
            res = ONE_Q30[30:0];
        end else begin
            res = v[30:0];
        end
        return res;
    endfunction

    // The last term is even in both series and so is added.
    logic signed [33:0] w_ss, w_cs;
    logic [30:0]        r_s, r_c;
    logic [1:0]         r_q3;

    assign w_ss = w_tay[TAY_STEPS].acc_s + signed'({2'b00, w_tay[TAY_STEPS].ts});
    assign w_cs = w_tay[TAY_STEPS].acc_c + signed'({2'b00, w_tay[TAY_STEPS].tc});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s  <= clamp_q30(w_ss);
            r_c  <= clamp_q30(w_cs);
            r_q3 <= w_tay[TAY_STEPS].q;
        end
    end

    logic [31:0]        w_sr, w_cr;
    logic [TRIG_MW-1:0] w_sm, w_cm;
    t_evg_trig          n_trig, r_trig;

    assign w_sr = (32'(r_s) + RND) >> (30 - FRAC_BITS);
    assign w_cr = (32'(r_c) + RND) >> (30 - FRAC_BITS);
    assign w_sm = w_sr[TRIG_MW-1:0];
    assign w_cm = w_cr[TRIG_MW-1:0];

    always_comb begin
        case (r_q3)
            QUAD_I: begin
                n_trig = '{sin_neg: 1'b0, sin_mag: w_sm, cos_neg: 1'b0, cos_mag: w_cm};
            end
            QUAD_II: begin
                n_trig = '{sin_neg: 1'b0, sin_mag: w_cm, cos_neg: 1'b1, cos_mag: w_sm};
            end
            QUAD_III: begin
                n_trig = '{sin_neg: 1'b1, sin_mag: w_sm, cos_neg: 1'b1, cos_mag: w_cm};
            end
            default: begin
                n_trig = '{sin_neg: 1'b1, sin_mag: w_cm, cos_neg: 1'b0, cos_mag: w_sm};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_trig <= n_trig;
        end
    end

    assign o_trig = r_trig;

endmodule

`default_nettype wire

// ===== src/ellipsoid_vertex_generator_unit.sv =====
// ============================================================================
// ellipsoid_vertex_generator_unit: UV-sphere ellipsoid vertex generator
// Turns a grid request (row j, column i) into a vertex position and texture
// coordinates of an ellipsoid with semi-axes a, b and c.
// ============================================================================
// Usage:
//   Radii and segment counts are written through the plain write port
//   (i_cfg_we, i_cfg_idx, i_cfg_data) while no item is in flight.
//   Requests enter on i_valid / o_ready; results leave on o_valid / i_ready,
//   one result item for every request item.
// Pipeline and throughput:
//   A request passes one input stage, 33 stages of the bit-per-stage
//   dividers for the angles and texture coordinates, 23 stages of the
//   sine/cosine series pipeline, two radius multiplier stages and the
//   output register. One item is taken every cycle while the receiver
//   takes results.
// Reset:
//   The configuration and valid registers read as zero and the pipeline
//   empties; with zero segment counts every request returns the error flag.
// Stall:
//   When a result waits in the output register and i_ready is low, the whole
//   pipeline holds and o_ready drops; nothing is lost or repeated.
// ============================================================================
`default_nettype none

module ellipsoid_vertex_generator_unit import evg_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_evg_in     i_item,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_evg_out         o_item,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    localparam int VLD_N = DIV_LAT + TRIG_LAT + 2;
    localparam int SB_W  = 2 + 17 + 17;

    // ------------------------------------------------------------------
    // Configuration registers.
    logic [31:0] r_radius_a, r_radius_b, r_radius_c;
    logic [10:0] r_lon_seg, r_lat_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_a <= '0;
            r_radius_b <= '0;
            r_radius_c <= '0;
            r_lon_seg  <= '0;
            r_lat_seg  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RADIUS_A: r_radius_a <= i_cfg_data;
                CFG_RADIUS_B: r_radius_b <= i_cfg_data;
                CFG_RADIUS_C: r_radius_c <= i_cfg_data;
                CFG_LON_SEG:  r_lon_seg  <= i_cfg_data[10:0];
                CFG_LAT_SEG:  r_lat_seg  <= i_cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves together.
    logic             w_en;
    logic             r_s0_vld;
    logic [VLD_N-1:0] r_vld;
    logic             r_out_vld;

    assign w_en    = !r_out_vld || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld  <= i_valid;
            r_vld     <= {r_vld[VLD_N-2:0], r_s0_vld};
            r_out_vld <= r_vld[VLD_N-1];
        end
    end

    // ------------------------------------------------------------------
    // Input stage and range checks.
    t_evg_in r_s0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0 <= i_item;
        end
    end

    logic signed [12:0] w_j, w_m, w_diff, w_aj;
    logic               w_err, w_close, w_neg;
    logic [DIV_NW-1:0]  w_nu, w_nv, w_nb, w_nl;
    logic [DIV_DW-1:0]  w_dn, w_dv, w_db;

    assign w_j    = 13'(r_s0.lat_index);
    assign w_m    = signed'({2'b00, r_lat_seg});
    assign w_diff = w_m - w_j;
    assign w_aj   = w_j[12] ? -w_j : w_j;
    assign w_neg  = w_j[12];

    assign w_err = (r_lon_seg == '0) || (r_lat_seg == '0)
                || (r_lon_seg > 11'(MAX_SEGMENTS)) || (r_lat_seg > 11'(MAX_SEGMENTS))
                || (w_j < -w_m) || (w_j > w_m) || (r_s0.lon_index > r_lon_seg);
    assign w_close = (r_s0.lon_index == r_lon_seg);

    // Round-to-nearest quotients: half the divisor is added to the dividend.
    assign w_nu = DIV_NW'({r_s0.lon_index, 16'b0}) + DIV_NW'(r_lon_seg >> 1);
    assign w_nv = DIV_NW'({w_diff[11:0], 16'b0}) + DIV_NW'(r_lat_seg);
    assign w_nb = {w_aj[10:0], 32'b0} + DIV_NW'({r_lat_seg, 1'b0});
    assign w_nl = {r_s0.lon_index, 32'b0} + DIV_NW'(r_lon_seg >> 1);
    assign w_dn = DIV_DW'(r_lon_seg);
    assign w_dv = DIV_DW'({r_lat_seg, 1'b0});
    assign w_db = {r_lat_seg, 2'b00};

    logic [DIV_QW-1:0] w_qu, w_qv, w_qb, w_ql;

    evg_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_u (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_nu), .i_den (w_dn), .o_quo (w_qu)
    );
    evg_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_v (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_nv), .i_den (w_dv), .o_quo (w_qv)
    );
    evg_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_b (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_nb), .i_den (w_db), .o_quo (w_qb)
    );
    evg_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div_l (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_nl), .i_den (w_dn), .o_quo (w_ql)
    );

    logic [2:0] w_sb1;

    evg_dly #(.W(3), .N(DIV_LAT)) u_dly_div (
        .i_clk (i_clk), .i_en (w_en), .i_d ({w_err, w_close, w_neg}), .o_d (w_sb1)
    );

    // ------------------------------------------------------------------
    // Angles and sine/cosine.
    logic [31:0] w_pb;
    t_evg_trig   w_tb, w_tl;

    // A southern row mirrors the phase around zero.
    assign w_pb = w_sb1[0] ? (32'd0 - w_qb) : w_qb;

    evg_trig u_trig_b (.i_clk (i_clk), .i_en (w_en), .i_phase (w_pb), .o_trig (w_tb));
    evg_trig u_trig_l (.i_clk (i_clk), .i_en (w_en), .i_phase (w_ql), .o_trig (w_tl));

    logic [SB_W-1:0] w_sb2;

    evg_dly #(.W(SB_W), .N(TRIG_LAT + 2)) u_dly_trig (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({w_sb1[2], w_sb1[1], w_qu[16:0], w_qv[16:0]}),
        .o_d   (w_sb2)
    );

    // ------------------------------------------------------------------
    // Radius scaling, rounded half away from zero on magnitudes.
    localparam logic [51:0] HALF_LSB = 52'(1) << (FRAC_BITS - 1);

    logic [51:0] w_m1x, w_m1y, w_m1z;
    logic [33:0] r_m1x, r_m1y, r_m1z;
    logic        r_m1x_neg, r_m1z_neg;
    t_evg_trig   r_m1_tl;

    assign w_m1x = 52'(r_radius_a) * 52'(w_tb.cos_mag) + HALF_LSB;
    assign w_m1y = 52'(r_radius_b) * 52'(w_tb.cos_mag) + HALF_LSB;
    assign w_m1z = 52'(r_radius_c) * 52'(w_tb.sin_mag) + HALF_LSB;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1x     <= 34'(w_m1x >> FRAC_BITS);
            r_m1y     <= 34'(w_m1y >> FRAC_BITS);
            r_m1z     <= 34'(w_m1z >> FRAC_BITS);
            r_m1x_neg <= w_tb.cos_neg;
            r_m1z_neg <= w_tb.sin_neg;
            r_m1_tl   <= w_tl;
        end
    end

    logic [51:0] w_m2x, w_m2y;
    logic [35:0] r_m2x, r_m2y, r_m2z;
    logic        r_m2x_neg, r_m2y_neg, r_m2z_neg;

    assign w_m2x = 52'(r_m1x) * 52'(r_m1_tl.cos_mag) + HALF_LSB;
    assign w_m2y = 52'(r_m1y) * 52'(r_m1_tl.sin_mag) + HALF_LSB;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2x     <= 36'(w_m2x >> FRAC_BITS);
            r_m2y     <= 36'(w_m2y >> FRAC_BITS);
            r_m2z     <= 36'(r_m1z);
            r_m2x_neg <= r_m1x_neg ^ r_m1_tl.cos_neg;
            r_m2y_neg <= r_m1x_neg ^ r_m1_tl.sin_neg;
            r_m2z_neg <= r_m1z_neg;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    logic     w_err2, w_close2;
    t_evg_out n_out, r_out;

    assign w_err2   = w_sb2[SB_W-1];
    assign w_close2 = w_sb2[SB_W-2];

    always_comb begin
        n_out = '0;
        if (w_err2) begin
            n_out.index_error = 1'b1;
        end else begin
            n_out.tex_u = w_sb2[33:17];
            n_out.tex_v = w_sb2[16:0];
            if (!w_close2) begin
                n_out.pos_x     = sat32(r_m2x_neg, r_m2x);
                n_out.pos_y     = sat32(r_m2y_neg, r_m2y);
                n_out.pos_z     = sat32(r_m2z_neg, r_m2z);
                n_out.pos_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

`default_nettype wire

// ===== tb/evg_checker.sv =====
// ============================================================================
// evg_checker: vertex predictor and result scoreboard
// Watches both channels of the ellipsoid vertex generator, computes the
// expected vertex and texture coordinates for every accepted request item
// and compares them with the result items in order.
// ============================================================================
`default_nettype none

module evg_checker
    import evg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_ready_in,
    input  wire t_evg_in     i_item,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire t_evg_out    i_out_item,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending,
    output int               o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] rad_a, rad_b, rad_c;
    logic [10:0] lon_seg, lat_seg;
    t_evg_out    vertex_q[$];

    initial begin
        o_errors  = 0;
        o_results = 0;
        o_pending = 0;
    end

    function automatic longint round_trig(longint v);
        longint unsigned mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // Sine and cosine of a phase given as a 32-bit fraction of a turn.
    task automatic phase_trig(input logic [31:0] phase, output longint sn,
                              output longint cs);
        longint unsigned r, x, x2, t;
        longint s, c, ss, cc;
        r  = phase[29:0];
        x  = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        s  = 0;
        c  = 0;
        t  = x;
        for (int k = 0; k < 7; k++) begin
            s += (k & 1) ? -longint'(t) : longint'(t);
            t = ((t * x2) >> 30) / longint'((2 * k + 2) * (2 * k + 3));
        end
        t = 64'd1 << 30;
        for (int k = 0; k < 7; k++) begin
            c += (k & 1) ? -longint'(t) : longint'(t);
            t = ((t * x2) >> 30) / longint'((2 * k + 1) * (2 * k + 2));
        end
        if (s < 0) s = 0;
        if (s > (64'd1 << 30)) s = 64'd1 << 30;
        if (c < 0) c = 0;
        if (c > (64'd1 << 30)) c = 64'd1 << 30;
        case (phase[31:30])
            2'd0: begin ss = s;  cc = c;  end
            2'd1: begin ss = c;  cc = -s; end
            2'd2: begin ss = -s; cc = -c; end
            default: begin ss = -c; cc = s; end
        endcase
        sn = round_trig(ss);
        cs = round_trig(cc);
    endtask

    function automatic longint scale_q16(longint v, longint f);
        logic neg;
        longint unsigned m;
        neg = (v < 0) != (f < 0);
        m = ((longint'(v < 0 ? -v : v) * longint'(f < 0 ? -f : f)) + 64'd32768) >> 16;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic predict_vertex(input t_evg_in req, output t_evg_out res);
        longint j, i, n, m;
        longint unsigned aj, pb, pl;
        longint sb, cb, sl, cl;
        j = req.lat_index;
        i = req.lon_index;
        n = lon_seg;
        m = lat_seg;
        res = '0;
        if (n == 0 || m == 0 || n > MAX_SEGMENTS || m > MAX_SEGMENTS ||
            j < -m || j > m || i > n) begin
            res.index_error = 1'b1;
            return;
        end
        res.tex_u = 17'((i * 65536 + n / 2) / n);
        res.tex_v = 17'(((m - j) * 65536 + m) / (2 * m));
        if (i < n) begin
            aj = (j < 0) ? -j : j;
            pb = ((aj << 32) + 2 * m) / (4 * m);
            pl = ((longint'(i) << 32) + n / 2) / n;
            if (j < 0) pb = -pb;
            phase_trig(pb[31:0], sb, cb);
            phase_trig(pl[31:0], sl, cl);
            res.pos_x = clamp32(scale_q16(scale_q16(longint'(rad_a), cb), cl));
            res.pos_y = clamp32(scale_q16(scale_q16(longint'(rad_b), cb), sl));
            res.pos_z = clamp32(scale_q16(longint'(rad_c), sb));
            res.pos_valid = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_evg_out want;
        if (!i_rst_n) begin
            rad_a <= '0; rad_b <= '0; rad_c <= '0;
            lon_seg <= '0; lat_seg <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIUS_A: rad_a <= i_cfg_data;
                    CFG_RADIUS_B: rad_b <= i_cfg_data;
                    CFG_RADIUS_C: rad_c <= i_cfg_data;
                    CFG_LON_SEG:  lon_seg <= i_cfg_data[10:0];
                    CFG_LAT_SEG:  lat_seg <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (i_valid && i_ready_in) begin
                predict_vertex(i_item, want);
                vertex_q.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                o_results <= o_results + 1;
                if (vertex_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result item %p", i_out_item);
                    o_errors <= o_errors + 1;
                end else begin
                    want = vertex_q.pop_front();
                    if (want !== i_out_item) begin
                        if (o_errors < 10) begin
                            $display("mismatch: expected %p", want);
                            $display("          actual   %p", i_out_item);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= vertex_q.size();
        end
    end
endmodule

`default_nettype wire

// ===== tb/tb_ellipsoid_vertex_generator_unit.sv =====
// ============================================================================
// tb_ellipsoid_vertex_generator_unit: stimulus and verdict
// Programs radii and segment counts over several settings, sends directed
// and random grid requests with random idling on both sides and reports
// whether the checker counted any failures.
// ============================================================================
`default_nettype none

module tb_ellipsoid_vertex_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import evg_pkg::*;

    localparam int LIMIT = 400000;
    localparam int DRAIN = 80;

    logic        clk, rst_n, in_valid, in_ready, out_valid, out_ready;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;
    t_evg_in     req;
    t_evg_out    res;
    int          errors, pending, results, cycles, sent;
    logic        calm;

    ellipsoid_vertex_generator_unit dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_item(req), .o_valid(out_valid), .i_ready(out_ready), .o_item(res),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    evg_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_ready_in(in_ready),
        .i_item(req), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_out_item(res), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .o_errors(errors), .o_pending(pending),
        .o_results(results)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("tb_ellipsoid_vertex_generator_unit: done, errors");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts until the final calm stretch.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Called at a falling edge; the last request item has already been taken.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    // Valid stays high after an item is taken so that items can follow back
    // to back; it drops during idling and before any pause.
    task automatic send(input int j, input int i);
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid <= 1'b1;
        req.lat_index <= 12'(j);
        req.lon_index <= 11'(i);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic setup(input logic [31:0] a, b, c, input int n, input int m);
        wait_idle();
        write_reg(CFG_RADIUS_A, a);
        write_reg(CFG_RADIUS_B, b);
        write_reg(CFG_RADIUS_C, c);
        write_reg(CFG_LON_SEG, 32'(n));
        write_reg(CFG_LAT_SEG, 32'(m));
    endtask

    task automatic random_phase(input int count);
        int n, m, j, i;
        for (int k = 0; k < count; k++) begin
            n = $urandom_range(1, 1024);
            m = $urandom_range(1, 1024);
            if (k % 60 == 0)
                setup($urandom(), $urandom(), $urandom(), n, m);
            if ($urandom_range(0, 9) == 0) begin
                j = int'($urandom_range(0, 4095)) - 2048;
                i = $urandom_range(0, 2047);
            end else begin
                j = int'($urandom_range(0, 2 * 1024)) - 1024;
                i = $urandom_range(0, 1024);
            end
            send(j, i);
        end
    endtask

    initial begin
        rst_n = 1'b0; in_valid = 1'b0; req = '0; calm = 1'b0; sent = 0;
        cfg_we = 1'b0; cfg_idx = CFG_RADIUS_A; cfg_data = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        // With zero segment counts every item reports an index error.
        send(0, 0);
        send(-2048, 2047);
        setup(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 4, 2);
        for (int j = -3; j <= 3; j++) send(j, (j + 3) % 6);
        send(0, 4);
        send(2, 5);
        setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1024, 1024);
        send(-1024, 0); send(1024, 1023); send(0, 1024); send(0, 256);
        send(-1025, 0); send(2047, 1025); send(1, 511);
        setup(0, 0, 0, 1, 1);
        send(-1, 0); send(1, 1); send(0, 0);
        setup(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 1025, 5);
        send(0, 0);
        setup(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 8, 2047);
        send(0, 0);
        random_phase(470);
        // Sender holds off until every pending result is back.
        wait_idle();
        random_phase(420);
        calm = 1'b1;
        random_phase(60);
        wait_idle();
        $display("sent %0d request items over varied radii and segment counts,", sent);
        $display("checked %0d result items with random idling on both channels", results);
        if (errors == 0) begin
            $display("tb_ellipsoid_vertex_generator_unit: done, clean");
        end else begin
            $display("tb_ellipsoid_vertex_generator_unit: done, errors");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== files.f =====
src/evg_pkg.sv
src/evg_dly.sv
src/evg_div.sv
src/evg_tstep.sv
src/evg_trig.sv
src/ellipsoid_vertex_generator_unit.sv
tb/evg_checker.sv
tb/tb_ellipsoid_vertex_generator_unit.sv
